FILE: src/hth_pkg.sv
// Package: shared types, codes and constants for the host table with aging.
`timescale 1ns / 1ps
package hth_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;

   // Result kinds
   localparam logic [1:0] KIND_CREATED = 2'd0;
   localparam logic [1:0] KIND_DELETED = 2'd1;
   localparam logic [1:0] KIND_PASSED  = 2'd2;
   localparam logic [1:0] KIND_FULL    = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_OWN_ADDRESS    = 3'd0;
   localparam logic [2:0] CSR_LAN_MASK       = 3'd1;
   localparam logic [2:0] CSR_CATEGORY       = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT        = 3'd3;
   localparam logic [2:0] CSR_CHECK_INTERVAL = 3'd4;

   // Category codes
   localparam logic [1:0] CAT_LAN = 2'd0;
   localparam logic [1:0] CAT_WAN = 2'd1;

   typedef struct packed {
      logic        cmd;
      logic [31:0] timestamp;
      logic        has_ethernet;
      logic        has_ipv4;
      logic [31:0] dest_address;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] host_address;
      logic [31:0] first_seen;
      logic [31:0] last_seen;
      logic        last;
   } rsp_type;

   // One table entry as held in a cell
   typedef struct packed {
      logic        mark;
      logic        valid;
      logic [31:0] addr;
      logic [31:0] first;
      logic [31:0] last;
   } cell_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_MARK_ALL,
      OP_MARK_AGE,
      OP_DELETE,
      OP_INSERT,
      OP_REFRESH
   } cell_op_type;

   // Broadcast control to every cell
   typedef struct packed {
      cell_op_type op;
      logic [31:0] dst;
      logic [31:0] ts;
      logic [31:0] timeout;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_DELETE,
      ST_UPDATE,
      ST_PASS
   } state_type;

endpackage

FILE: src/hth_cell.sv
// Module: one cell of the sorted host chain, holding a single entry.
`timescale 1ns / 1ps
module hth_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  hth_pkg::cell_ctl_type ctl,
   input  hth_pkg::cell_type     left_cell,
   input  hth_pkg::cell_type     right_cell,
   input  logic                  gt_in,
   input  logic                  shift_in,
   output hth_pkg::cell_type     entry_out,
   output logic                  gt_out,
   output logic                  shift_out,
   output logic                  hit,
   output logic                  first_mark
);
   import hth_pkg::*;

   cell_type cell_ff;
   cell_type cell_in;
   logic [31:0] idle_time;

   assign entry_out  = cell_ff;
   // Free cells sort after every address, so the chain stays packed
   assign gt_out     = !cell_ff.valid || (cell_ff.addr > ctl.dst);
   assign hit        = cell_ff.valid && (cell_ff.addr == ctl.dst);
   assign shift_out  = shift_in | cell_ff.mark;
   assign first_mark = cell_ff.mark & !shift_in;
   assign idle_time  = ctl.ts - cell_ff.last;

   // Next entry for each broadcast operation
   always_comb begin
      cell_in = cell_ff;
      case (ctl.op)
         OP_MARK_ALL: cell_in.mark = cell_ff.valid;
         OP_MARK_AGE: cell_in.mark = cell_ff.valid && (idle_time >= ctl.timeout);
         OP_DELETE: begin
            if (shift_out) cell_in = right_cell;
         end
         OP_INSERT: begin
            if (gt_out) begin
               if (gt_in) begin
                  cell_in = left_cell;
               end else begin
                  cell_in = '{mark: 1'b0, valid: 1'b1, addr: ctl.dst,
                              first: ctl.ts, last: ctl.ts};
               end
            end
         end
         OP_REFRESH: begin
            if (hit) cell_in.last = ctl.ts;
         end
         default: cell_in = cell_ff;
      endcase
   end

   // Hold the entry; clear valid and mark on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
         cell_ff.mark  <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

endmodule

FILE: src/ip_host_table_with_aging.sv
// Top level: host table with timeout aging built as a sorted chain of cells.
//
//  channel | ports                      | role
//  req     | req_valid/ready, req_data  | packet event or flush command in
//  rsp     | rsp_valid/ready, rsp_data  | created/deleted/passed/full results out
//  csr     | csr_valid/ready, index,data| register writes, always ready
//
// A packet with both headers goes through idle, mark, delete check, update and
// pass, staying in delete check while hosts remain to delete; a flush or a packet
// missing a header goes through idle, mark and delete check only. Created and
// full results are emitted in the update state. The cell chain removes one host per
// cycle in address order while the result output is free. Synchronous reset empties
// the table at once. A stalled result holds the sequencer in place; a new item is
// taken only when the previous is done.
`timescale 1ns / 1ps
module ip_host_table_with_aging #(
   parameter int TABLE_ENTRIES = hth_pkg::TABLE_ENTRIES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hth_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hth_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import hth_pkg::*;

   // Configuration registers
   logic [31:0] own_ff, mask_ff, timeout_ff, interval_ff;
   logic [1:0]  category_ff;

   logic [31:0] sweep_ff, sweep_in;
   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [31:0] pass_first_ff, pass_first_in, pass_last_ff, pass_last_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   cell_ctl_type ctl;
   cell_type     cells   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] gt_v, shift_v, hit_v, first_v, mark_v;

   logic        emit;
   rsp_type     emit_data;
   logic        out_free;
   logic        any_hit, any_mark, other_mark, full, headers, sweep_due, accept_dst;
   logic        same_lan;
   cell_type    hit_cell, del_cell;

   // Chain of cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      cell_type left_c, right_c;
      logic     gt_l, sh_l;
      if (i == 0) begin : g_head
         assign left_c = '0;
         assign gt_l   = 1'b0;
         assign sh_l   = 1'b0;
      end else begin : g_body
         assign left_c = cells[i-1];
         assign gt_l   = gt_v[i-1];
         assign sh_l   = shift_v[i-1];
      end
      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign right_c = '0;
      end else begin : g_mid
         assign right_c = cells[i+1];
      end
      hth_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_cell  (left_c),
         .right_cell (right_c),
         .gt_in      (gt_l),
         .shift_in   (sh_l),
         .entry_out  (cells[i]),
         .gt_out     (gt_v[i]),
         .shift_out  (shift_v[i]),
         .hit        (hit_v[i]),
         .first_mark (first_v[i])
      );
      assign mark_v[i] = cells[i].mark;
   end

   // Pick the hit entry and the lowest marked entry
   always_comb begin
      hit_cell = '0;
      del_cell = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit_v[i])   hit_cell = hit_cell | cells[i];
         if (first_v[i]) del_cell = del_cell | cells[i];
      end
   end

   assign any_hit    = |hit_v;
   assign any_mark   = |mark_v;
   assign other_mark = |(mark_v & ~first_v);
   assign full       = cells[TABLE_ENTRIES-1].valid;
   assign headers    = req_ff.has_ethernet && req_ff.has_ipv4;
   assign sweep_due  = (interval_ff != 32'd0) && ((req_ff.timestamp - sweep_ff) >= interval_ff);

   // Destination filter
   assign same_lan = (req_ff.dest_address & mask_ff) == (own_ff & mask_ff);
   always_comb begin
      accept_dst = 1'b1;
      if (req_ff.dest_address == own_ff)            accept_dst = 1'b0;
      if (req_ff.dest_address[31:24] == 8'd127)     accept_dst = 1'b0;
      if (req_ff.dest_address[31:28] == 4'hE)       accept_dst = 1'b0;
      if (req_ff.dest_address == 32'hFFFF_FFFF)     accept_dst = 1'b0;
      if (category_ff == CAT_LAN && !same_lan)      accept_dst = 1'b0;
      if (category_ff == CAT_WAN && same_lan)       accept_dst = 1'b0;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: next state, cell operation and result
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      pass_first_in = pass_first_ff;
      pass_last_in  = pass_last_ff;
      req_ready     = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;
      ctl.op        = OP_HOLD;
      ctl.dst       = req_ff.dest_address;
      ctl.ts        = req_ff.timestamp;
      ctl.timeout   = timeout_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = ST_MARK;
         end
         ST_MARK: begin
            if (req_ff.cmd) begin
               ctl.op = OP_MARK_ALL;
            end else if (sweep_due) begin
               ctl.op   = OP_MARK_AGE;
               sweep_in = req_ff.timestamp;
            end
            state_in = ST_DELETE;
         end
         ST_DELETE: begin
            if (any_mark) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_data = '{kind: KIND_DELETED, host_address: del_cell.addr,
                                first_seen: del_cell.first, last_seen: del_cell.last,
                                last: !other_mark && (req_ff.cmd || !headers)};
                  ctl.op    = OP_DELETE;
               end
            end else if (req_ff.cmd || !headers) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (accept_dst && !any_hit) begin
               if (out_free) begin
                  emit          = 1'b1;
                  emit_data     = '{kind: full ? KIND_FULL : KIND_CREATED,
                                    host_address: req_ff.dest_address,
                                    first_seen: req_ff.timestamp,
                                    last_seen: req_ff.timestamp, last: 1'b0};
                  ctl.op        = full ? OP_HOLD : OP_INSERT;
                  pass_first_in = full ? 32'd0 : req_ff.timestamp;
                  pass_last_in  = full ? 32'd0 : req_ff.timestamp;
                  state_in      = ST_PASS;
               end
            end else begin
               if (accept_dst) ctl.op = OP_REFRESH;
               pass_first_in = any_hit ? hit_cell.first : 32'd0;
               pass_last_in  = any_hit ? (accept_dst ? req_ff.timestamp : hit_cell.last)
                                       : 32'd0;
               state_in      = ST_PASS;
            end
         end
         ST_PASS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{kind: KIND_PASSED, host_address: req_ff.dest_address,
                             first_seen: pass_first_ff, last_seen: pass_last_ff,
                             last: 1'b1};
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer state and sweep time
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sweep_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   // Capture the accepted item and pass-on times
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      pass_first_ff <= pass_first_in;
      pass_last_ff  <= pass_last_in;
   end

   // Output register: load on emit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= emit_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff      <= 32'd0;
         mask_ff     <= 32'hFFFF_FF00;
         category_ff <= 2'd2;
         timeout_ff  <= 32'd60;
         interval_ff <= 32'd10;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:    own_ff      <= csr_wdata;
            CSR_LAN_MASK:       mask_ff     <= csr_wdata;
            CSR_CATEGORY:       category_ff <= csr_wdata[1:0];
            CSR_TIMEOUT:        timeout_ff  <= csr_wdata;
            CSR_CHECK_INTERVAL: interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

FILE: verif/ip_host_table_with_aging_tb.sv
// Testbench for the host table with aging: directed table, then random phases per setting.
`timescale 1ns / 1ps
module ip_host_table_with_aging_tb;
   import hth_pkg::*;

   localparam int ENTRIES    = TABLE_ENTRIES_DEF;
   localparam int DOG_LIMIT  = 4000;
   localparam int LONG_HOLD  = 300;
   localparam int SETTLE     = 60;

   typedef struct {
      req_type pkt;
      bit      typed;
      rsp_type want;
   } drow_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // shadow of the registers and the host table
   logic [31:0] own_addr, lan_mask, timeout_s, interval_s, sweep_time;
   logic [1:0]  category;
   bit          tbl_valid [ENTRIES];
   logic [31:0] tbl_addr [ENTRIES];
   logic [31:0] tbl_first [ENTRIES];
   logic [31:0] tbl_last [ENTRIES];

   rsp_type     pending_rsp [$];
   rsp_type     step_rsp [$];
   drow_type    directed [$];
   logic [31:0] addr_pool [40];
   logic [31:0] now_ts;
   int          fail_count;
   int          mismatch_count;
   bit          no_idle;
   bit          hold_request;
   bit          transfer_seen;

   ip_host_table_with_aging u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic rsp_type host_event(logic [1:0] kind, logic [31:0] a, logic [31:0] f,
                                          logic [31:0] l, logic fin);
      rsp_type r;
      r.kind = kind;
      r.host_address = a;
      r.first_seen = f;
      r.last_seen = l;
      r.last = fin;
      return r;
   endfunction

   function automatic bit host_wanted(logic [31:0] a);
      bit on_lan;
      on_lan = (a & lan_mask) == (own_addr & lan_mask);
      if (a == own_addr || a[31:24] == 8'd127 || a[31:28] == 4'he || a == 32'hffffffff)
         return 0;
      if (category == CAT_LAN && !on_lan) return 0;
      if (category == CAT_WAN && on_lan) return 0;
      return 1;
   endfunction

   // drop marked hosts, lowest address first
   task automatic evict_marked(inout bit mark [ENTRIES]);
      int best;
      forever begin
         best = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (mark[i] && (best < 0 || tbl_addr[i] < tbl_addr[best])) best = i;
         if (best < 0) return;
         step_rsp.push_back(host_event(KIND_DELETED, tbl_addr[best], tbl_first[best],
                                       tbl_last[best], 1'b0));
         mark[best] = 0;
         tbl_valid[best] = 0;
      end
   endtask

   // work out the results of one accepted item and advance the shadow table
   task automatic predict_host_table(input req_type r);
      bit          mark [ENTRIES];
      int          hit;
      int          slot;
      logic [31:0] pf, pl;
      step_rsp.delete();
      if (r.cmd) begin
         for (int i = 0; i < ENTRIES; i++) mark[i] = tbl_valid[i];
         evict_marked(mark);
      end else begin
         if (interval_s != 0 && 32'(r.timestamp - sweep_time) >= interval_s) begin
            for (int i = 0; i < ENTRIES; i++)
               mark[i] = tbl_valid[i] && 32'(r.timestamp - tbl_last[i]) >= timeout_s;
            evict_marked(mark);
            sweep_time = r.timestamp;
         end
         if (r.has_ethernet && r.has_ipv4) begin
            hit = -1;
            pf = '0;
            pl = '0;
            for (int i = 0; i < ENTRIES; i++)
               if (tbl_valid[i] && tbl_addr[i] == r.dest_address) hit = i;
            if (host_wanted(r.dest_address)) begin
               if (hit >= 0) begin
                  tbl_last[hit] = r.timestamp;
               end else begin
                  slot = -1;
                  for (int i = ENTRIES - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
                  if (slot >= 0) begin
                     tbl_valid[slot] = 1;
                     tbl_addr[slot] = r.dest_address;
                     tbl_first[slot] = r.timestamp;
                     tbl_last[slot] = r.timestamp;
                     hit = slot;
                     step_rsp.push_back(host_event(KIND_CREATED, r.dest_address,
                                                   r.timestamp, r.timestamp, 1'b0));
                  end else begin
                     step_rsp.push_back(host_event(KIND_FULL, r.dest_address,
                                                   r.timestamp, r.timestamp, 1'b0));
                  end
               end
            end
            if (hit >= 0) begin
               pf = tbl_first[hit];
               pl = tbl_last[hit];
            end
            step_rsp.push_back(host_event(KIND_PASSED, r.dest_address, pf, pl, 1'b0));
         end
      end
      if (step_rsp.size() > 0) step_rsp[step_rsp.size() - 1].last = 1'b1;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one item, hold it until the transfer, then predict
   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_host_table(r);
      if (typed) pending_rsp.push_back(want);
      else foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_OWN_ADDRESS:    own_addr = val;
         CSR_LAN_MASK:       lan_mask = val;
         CSR_CATEGORY:       category = val[1:0];
         CSR_TIMEOUT:        timeout_s = val;
         CSR_CHECK_INTERVAL: interval_s = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type random_packet();
      req_type r;
      int roll;
      roll = $urandom_range(0, 99);
      r.cmd = (roll < 3);
      r.has_ethernet = ($urandom_range(0, 99) >= 8);
      r.has_ipv4 = ($urandom_range(0, 99) >= 8);
      // timestamps mostly creep forward, with the odd jump across the wrap
      if ($urandom_range(0, 99) < 5) now_ts = now_ts + $urandom();
      else now_ts = now_ts + $urandom_range(0, 8);
      r.timestamp = r.cmd ? $urandom() : now_ts;
      roll = $urandom_range(0, 99);
      if (roll < 75)      r.dest_address = addr_pool[$urandom_range(0, 39)];
      else if (roll < 85) r.dest_address = $urandom();
      else if (roll < 88) r.dest_address = own_addr;
      else if (roll < 91) r.dest_address = {8'd127, 24'($urandom())};
      else if (roll < 94) r.dest_address = {4'he, 28'($urandom())};
      else if (roll < 97) r.dest_address = 32'hffffffff;
      else                r.dest_address = (own_addr & lan_mask) | ($urandom() & ~lan_mask);
      return r;
   endfunction

   task automatic run_phase(input logic [31:0] own, input logic [31:0] mask,
                            input logic [1:0] cat, input logic [31:0] tmo,
                            input logic [31:0] intv, input int count, input int hold_at,
                            input int pause_at);
      rsp_type none;
      none = '0;
      write_reg(CSR_OWN_ADDRESS, own);
      write_reg(CSR_LAN_MASK, mask);
      write_reg(CSR_CATEGORY, {30'd0, cat});
      write_reg(CSR_TIMEOUT, tmo);
      write_reg(CSR_CHECK_INTERVAL, intv);
      // more hosts than cells, half of them on the local subnet
      foreach (addr_pool[i])
         addr_pool[i] = (i < 20) ? ((own & mask) | ($urandom() & ~mask)) : $urandom();
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) hold_request = 1;
         if (n == pause_at) begin
            req_valid <= 1'b0;
            while (pending_rsp.size() > 0) @(posedge clock);
         end
         send_item(random_packet(), 1'b0, none);
      end
      drain_results();
   endtask

   // receiver: check each transfer, stall at random
   initial begin : rsp_side
      rsp_type want;
      int      stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               fail_count++;
               if (mismatch_count++ < 10)
                  $display("unexpected result kind=%0d addr=%h", rsp_data.kind,
                           rsp_data.host_address);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.host_address !== want.host_address
                   || rsp_data.first_seen !== want.first_seen
                   || rsp_data.last_seen !== want.last_seen || rsp_data.last !== want.last) begin
                  fail_count++;
                  if (mismatch_count++ < 10)
                     $display("mismatch: exp k=%0d a=%h f=%h l=%h e=%b, got k=%0d a=%h f=%h l=%h e=%b",
                              want.kind, want.host_address, want.first_seen, want.last_seen,
                              want.last, rsp_data.kind, rsp_data.host_address,
                              rsp_data.first_seen, rsp_data.last_seen, rsp_data.last);
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 0;
            stall = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 20)
               stall = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
         end
      end
   end

   // watchdog: count cycles without any transfer
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         transfer_seen = (req_valid && req_ready) || (rsp_valid && rsp_ready)
                         || (csr_valid && csr_ready);
         if (transfer_seen || reset) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= DOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic add_row(input logic cmd, input logic [31:0] ts, input logic eth,
                          input logic ip4, input logic [31:0] dst, input bit typed,
                          input rsp_type want);
      drow_type d;
      d.pkt.cmd = cmd;
      d.pkt.timestamp = ts;
      d.pkt.has_ethernet = eth;
      d.pkt.has_ipv4 = ip4;
      d.pkt.dest_address = dst;
      d.typed = typed;
      d.want = want;
      directed.push_back(d);
   endtask

   initial begin : stimulus
      rsp_type none;
      none = '0;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_OWN_ADDRESS;
      csr_wdata = '0;
      fail_count = 0;
      mismatch_count = 0;
      no_idle = 0;
      hold_request = 0;
      now_ts = '0;
      own_addr = '0;
      lan_mask = 32'hffffff00;
      category = 2'd2;
      timeout_s = 32'd60;
      interval_s = 32'd10;
      sweep_time = '0;
      foreach (tbl_valid[i]) tbl_valid[i] = 0;

      // filtered addresses just after reset, then create, refresh, age and flush
      add_row(0, 1, 1, 1, 32'h7f000001, 1, host_event(KIND_PASSED, 32'h7f000001, 0, 0, 1));
      add_row(0, 2, 1, 1, 32'he0000001, 1, host_event(KIND_PASSED, 32'he0000001, 0, 0, 1));
      add_row(0, 3, 1, 1, 32'hefffffff, 1, host_event(KIND_PASSED, 32'hefffffff, 0, 0, 1));
      add_row(0, 3, 1, 1, 32'hffffffff, 1, host_event(KIND_PASSED, 32'hffffffff, 0, 0, 1));
      add_row(0, 4, 1, 1, 32'h00000000, 1, host_event(KIND_PASSED, 32'h00000000, 0, 0, 1));
      add_row(0, 4, 0, 1, 32'h0a010101, 0, none);
      add_row(0, 5, 1, 1, 32'h0a010101, 0, none);
      add_row(0, 6, 1, 1, 32'h00000007, 0, none);
      add_row(0, 7, 1, 1, 32'h0a010101, 1, host_event(KIND_PASSED, 32'h0a010101, 5, 7, 1));
      add_row(0, 20, 1, 0, 32'h12345678, 0, none);
      add_row(0, 100, 0, 0, 32'h0a010101, 0, none);
      add_row(1, 0, 0, 0, 32'h0, 0, none);
      add_row(0, 101, 1, 1, 32'hc0a80101, 0, none);
      add_row(0, 102, 1, 1, 32'hfffffffe, 0, none);
      add_row(1, 32'hffffffff, 1, 1, 32'hffffffff, 0, none);
      add_row(0, 32'hffffffff, 1, 1, 32'h01020304, 0, none);
      add_row(0, 0, 1, 1, 32'h01020304, 1,
              host_event(KIND_PASSED, 32'h01020304, 32'hffffffff, 0, 1));
      add_row(0, 0, 1, 1, 32'hdfffffff, 0, none);
      add_row(0, 0, 1, 1, 32'hf0000000, 0, none);
      add_row(1, 0, 0, 0, 32'h0, 0, none);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i].pkt, directed[i].typed, directed[i].want);
      drain_results();

      now_ts = $urandom();
      run_phase(32'hc0a80001, 32'hffffff00, CAT_LAN, 32'd30, 32'd5, 65, -1, 30);
      run_phase($urandom(), 32'hffffffff, CAT_WAN, 32'd0, 32'd1, 65, -1, -1);
      run_phase($urandom(), 32'hffff0000, 2'd2, 32'hffffffff, 32'hffffffff, 65, 20, -1);
      no_idle = 1;
      run_phase($urandom(), 32'h00000000, 2'd3, 32'd40, 32'd0, 65, -1, -1);
      no_idle = 0;
      run_phase(32'hffffffff, 32'hffffff00, CAT_LAN, 32'd20, 32'd3, 65, -1, -1);
      run_phase(32'h00000000, 32'hffffff00, 2'd2, 32'd60, 32'd10, 65, 40, -1);

      if (pending_rsp.size() > 0) fail_count++;
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
src/hth_pkg.sv
src/hth_cell.sv
src/ip_host_table_with_aging.sv
verif/ip_host_table_with_aging_tb.sv
